FILE: rtl/assert_macros.svh
// Assertion macros shared by the HSV to RGB converter modules.
// Each macro samples on the rising clock edge and is disabled while reset is held low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled clock edge out of reset.
`define H2R_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("h2r assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define H2R_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("h2r implication failed");

`endif

FILE: rtl/h2r_pkg.sv
// Package for the HSV to RGB converter: constants, sector codes and stage bundles.
// It depends on nothing; every module of the converter imports it.
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  localparam int HUE_W = 9;
  localparam int CH_W = 8;
  localparam int REM_W = 6;
  localparam int NUMQ_W = 14;
  localparam int PRODP_W = 16;
  localparam int PRODQ_W = 22;

  localparam int HUE_SPAN = 360;
  localparam int SECTOR_DEG = 60;
  localparam int FULL_SCALE = 255;
  localparam int DEN_Q = FULL_SCALE * SECTOR_DEG;

  // Reciprocals floor(2**K / D); the estimate is never more than one low.
  localparam int RECIP_P_SHIFT = 16;
  localparam int RECIP_P = (1 << RECIP_P_SHIFT) / FULL_SCALE;
  localparam int RECIP_Q_SHIFT = 22;
  localparam int RECIP_Q = (1 << RECIP_Q_SHIFT) / DEN_Q;
  localparam int RECIP_W = 9;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic              valid;
    sector_t           sector;
    logic [REM_W-1:0]  rem;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } h2r_sect_t;

  typedef struct packed {
    logic                valid;
    sector_t             sector;
    logic [CH_W-1:0]     val;
    logic [PRODP_W-1:0]  xp;
    logic [PRODQ_W-1:0]  xq;
    logic [PRODQ_W-1:0]  xt;
  } h2r_prod_t;

endpackage

`default_nettype wire

FILE: rtl/h2r_sector.sv
// Hue wrap and sector split stages of the HSV to RGB converter.
// Depends on h2r_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module h2r_sector
  import h2r_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [HUE_W-1:0]  in_hue,
  input  wire logic [CH_W-1:0]   in_sat,
  input  wire logic [CH_W-1:0]   in_val,
  output h2r_sect_t              sect_o
);

  logic             s1_valid_r;
  logic [HUE_W-1:0] s1_hue_r;
  logic [HUE_W-1:0] s1_hue_nxt;
  logic [CH_W-1:0]  s1_sat_r;
  logic [CH_W-1:0]  s1_val_r;
  h2r_sect_t        sect_r;
  h2r_sect_t        sect_nxt;

  always_comb begin
    if (in_hue >= HUE_W'(HUE_SPAN)) begin
      s1_hue_nxt = in_hue - HUE_W'(HUE_SPAN);
    end else begin
      s1_hue_nxt = in_hue;
    end
  end

  always_comb begin
    sect_nxt.valid = s1_valid_r;
    sect_nxt.sat = s1_sat_r;
    sect_nxt.val = s1_val_r;
    if (s1_hue_r < HUE_W'(SECTOR_DEG)) begin
      sect_nxt.sector = SEC_RED_YEL;
      sect_nxt.rem = REM_W'(s1_hue_r);
    end else if (s1_hue_r < HUE_W'(2 * SECTOR_DEG)) begin
      sect_nxt.sector = SEC_YEL_GRN;
      sect_nxt.rem = REM_W'(s1_hue_r - HUE_W'(SECTOR_DEG));
    end else if (s1_hue_r < HUE_W'(3 * SECTOR_DEG)) begin
      sect_nxt.sector = SEC_GRN_CYN;
      sect_nxt.rem = REM_W'(s1_hue_r - HUE_W'(2 * SECTOR_DEG));
    end else if (s1_hue_r < HUE_W'(4 * SECTOR_DEG)) begin
      sect_nxt.sector = SEC_CYN_BLU;
      sect_nxt.rem = REM_W'(s1_hue_r - HUE_W'(3 * SECTOR_DEG));
    end else if (s1_hue_r < HUE_W'(5 * SECTOR_DEG)) begin
      sect_nxt.sector = SEC_BLU_MAG;
      sect_nxt.rem = REM_W'(s1_hue_r - HUE_W'(4 * SECTOR_DEG));
    end else begin
      sect_nxt.sector = SEC_MAG_RED;
      sect_nxt.rem = REM_W'(s1_hue_r - HUE_W'(5 * SECTOR_DEG));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sect_r.valid <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      sect_r.valid <= sect_nxt.valid;
    end
    s1_hue_r <= s1_hue_nxt;
    s1_sat_r <= in_sat;
    s1_val_r <= in_val;
    sect_r.sector <= sect_nxt.sector;
    sect_r.rem <= sect_nxt.rem;
    sect_r.sat <= sect_nxt.sat;
    sect_r.val <= sect_nxt.val;
  end

  assign sect_o = sect_r;

  `H2R_ASSERT(a_rem_in_sector, clk, rst_n, sect_r.rem < REM_W'(SECTOR_DEG))
  `H2R_ASSERT(a_hue_wrapped, clk, rst_n, s1_hue_r < HUE_W'(HUE_SPAN))

endmodule

`default_nettype wire

FILE: rtl/h2r_scale.sv
// Numerator and brightness product stages of the HSV to RGB converter.
// Depends on h2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2r_scale
  import h2r_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire h2r_sect_t  sect_i,
  output h2r_prod_t       prod_o
);

  logic              s3_valid_r;
  sector_t           s3_sector_r;
  logic [CH_W-1:0]   s3_val_r;
  logic [CH_W-1:0]   s3_np_r;
  logic [NUMQ_W-1:0] s3_nq_r;
  logic [NUMQ_W-1:0] s3_nt_r;
  logic [CH_W-1:0]   s3_np_nxt;
  logic [NUMQ_W-1:0] s3_nq_nxt;
  logic [NUMQ_W-1:0] s3_nt_nxt;
  logic [REM_W-1:0]  rem_c;
  logic [NUMQ_W-1:0] sr_prod;
  logic [NUMQ_W-1:0] sc_prod;
  h2r_prod_t         prod_r;

  always_comb begin
    rem_c = REM_W'(SECTOR_DEG) - sect_i.rem;
    sr_prod = NUMQ_W'(sect_i.sat) * NUMQ_W'(sect_i.rem);
    sc_prod = NUMQ_W'(sect_i.sat) * NUMQ_W'(rem_c);
    s3_np_nxt = CH_W'(FULL_SCALE) - sect_i.sat;
    s3_nq_nxt = NUMQ_W'(DEN_Q) - sr_prod;
    s3_nt_nxt = NUMQ_W'(DEN_Q) - sc_prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      prod_r.valid <= 1'b0;
    end else begin
      s3_valid_r <= sect_i.valid;
      prod_r.valid <= s3_valid_r;
    end
    s3_sector_r <= sect_i.sector;
    s3_val_r <= sect_i.val;
    s3_np_r <= s3_np_nxt;
    s3_nq_r <= s3_nq_nxt;
    s3_nt_r <= s3_nt_nxt;
    prod_r.sector <= s3_sector_r;
    prod_r.val <= s3_val_r;
    prod_r.xp <= PRODP_W'(s3_val_r) * PRODP_W'(s3_np_r);
    prod_r.xq <= PRODQ_W'(s3_val_r) * PRODQ_W'(s3_nq_r);
    prod_r.xt <= PRODQ_W'(s3_val_r) * PRODQ_W'(s3_nt_r);
  end

  assign prod_o = prod_r;

endmodule

`default_nettype wire

FILE: rtl/h2r_divide.sv
// Constant division and channel selection stages of the HSV to RGB converter.
// Depends on h2r_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module h2r_divide
  import h2r_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire h2r_prod_t         prod_i,
  output logic                   out_valid,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue
);

  localparam int EP_W = PRODP_W + RECIP_W;
  localparam int EQ_W = PRODQ_W + RECIP_W;

  logic              s5_valid_r;
  sector_t           s5_sector_r;
  logic [CH_W-1:0]   s5_val_r;
  logic [PRODP_W-1:0] s5_xp_r;
  logic [PRODQ_W-1:0] s5_xq_r;
  logic [PRODQ_W-1:0] s5_xt_r;
  logic [CH_W-1:0]   s5_ep_r;
  logic [CH_W-1:0]   s5_eq_r;
  logic [CH_W-1:0]   s5_et_r;
  logic [EP_W-1:0]   mp_full;
  logic [EQ_W-1:0]   mq_full;
  logic [EQ_W-1:0]   mt_full;

  logic [PRODP_W-1:0] res_p;
  logic [PRODQ_W-1:0] res_q;
  logic [PRODQ_W-1:0] res_t;
  logic [CH_W-1:0]   p_c;
  logic [CH_W-1:0]   q_c;
  logic [CH_W-1:0]   t_c;

  logic              valid_r;
  logic [CH_W-1:0]   red_r;
  logic [CH_W-1:0]   green_r;
  logic [CH_W-1:0]   blue_r;
  logic [CH_W-1:0]   red_nxt;
  logic [CH_W-1:0]   green_nxt;
  logic [CH_W-1:0]   blue_nxt;
  logic [CH_W-1:0]   val_r;

  always_comb begin
    mp_full = EP_W'(prod_i.xp) * EP_W'(RECIP_P);
    mq_full = EQ_W'(prod_i.xq) * EQ_W'(RECIP_Q);
    mt_full = EQ_W'(prod_i.xt) * EQ_W'(RECIP_Q);
  end

  always_comb begin
    res_p = s5_xp_r - PRODP_W'(s5_ep_r) * PRODP_W'(FULL_SCALE);
    res_q = s5_xq_r - PRODQ_W'(s5_eq_r) * PRODQ_W'(DEN_Q);
    res_t = s5_xt_r - PRODQ_W'(s5_et_r) * PRODQ_W'(DEN_Q);
    p_c = (res_p >= PRODP_W'(FULL_SCALE)) ? s5_ep_r + 1'b1 : s5_ep_r;
    q_c = (res_q >= PRODQ_W'(DEN_Q)) ? s5_eq_r + 1'b1 : s5_eq_r;
    t_c = (res_t >= PRODQ_W'(DEN_Q)) ? s5_et_r + 1'b1 : s5_et_r;
  end

  always_comb begin
    unique case (s5_sector_r)
      SEC_RED_YEL: begin
        red_nxt = s5_val_r; green_nxt = t_c; blue_nxt = p_c;
      end
      SEC_YEL_GRN: begin
        red_nxt = q_c; green_nxt = s5_val_r; blue_nxt = p_c;
      end
      SEC_GRN_CYN: begin
        red_nxt = p_c; green_nxt = s5_val_r; blue_nxt = t_c;
      end
      SEC_CYN_BLU: begin
        red_nxt = p_c; green_nxt = q_c; blue_nxt = s5_val_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = t_c; green_nxt = p_c; blue_nxt = s5_val_r;
      end
      default: begin
        red_nxt = s5_val_r; green_nxt = p_c; blue_nxt = q_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      s5_valid_r <= prod_i.valid;
      valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_sector_r <= prod_i.sector;
    s5_val_r <= prod_i.val;
    s5_xp_r <= prod_i.xp;
    s5_xq_r <= prod_i.xq;
    s5_xt_r <= prod_i.xt;
    s5_ep_r <= mp_full[RECIP_P_SHIFT +: CH_W];
    s5_eq_r <= mq_full[RECIP_Q_SHIFT +: CH_W];
    s5_et_r <= mt_full[RECIP_Q_SHIFT +: CH_W];
    red_r <= red_nxt;
    green_r <= green_nxt;
    blue_r <= blue_nxt;
    val_r <= s5_val_r;
  end

  assign out_valid = valid_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;

  `H2R_ASSERT_IMP(a_p_estimate, clk, rst_n, s5_valid_r, res_p < PRODP_W'(2 * FULL_SCALE))
  `H2R_ASSERT_IMP(a_q_estimate, clk, rst_n, s5_valid_r, res_q < PRODQ_W'(2 * DEN_Q))
  `H2R_ASSERT_IMP(a_one_channel_full, clk, rst_n, valid_r,
    (red_r == val_r) || (green_r == val_r) || (blue_r == val_r))

endmodule

`default_nettype wire

FILE: rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: six-stage pipeline, one pixel per clock.
// Depends on h2r_pkg, h2r_sector, h2r_scale and h2r_divide.
//
// Usage:
//   Input channel: a pixel transfer happens at each rising edge where start is
//   high and busy is low. busy is held low, so a pixel may be offered in every
//   cycle. in_hue_degrees is wrapped modulo 360 before conversion.
//   Result channel: out_valid is high for exactly one cycle per pixel, with
//   out_red, out_green and out_blue valid in that cycle. The receiver cannot
//   stall, and results leave in the order the pixels arrived.
//   Stages, in order: wrap, sector split, numerators, brightness products,
//   reciprocal estimate, correction and channel select. Throughput: one
//   pixel per cycle, set by the fully pipelined multipliers with one register
//   after each.
//   Reset: a synchronous low level on rst_n clears all valid bits; pixels in
//   flight are dropped and no result strobes until new pixels arrive.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import h2r_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [HUE_W-1:0]  in_hue_degrees,
  input  wire logic [CH_W-1:0]   in_saturation,
  input  wire logic [CH_W-1:0]   in_brightness,
  output logic                   out_valid,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue
);

  logic      in_xfer;
  h2r_sect_t sect;
  h2r_prod_t prod;

  assign busy = 1'b0;
  assign in_xfer = start && !busy;

  h2r_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .in_hue   (in_hue_degrees),
    .in_sat   (in_saturation),
    .in_val   (in_brightness),
    .sect_o   (sect)
  );

  h2r_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .sect_i (sect),
    .prod_o (prod)
  );

  h2r_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .prod_i    (prod),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

`default_nettype wire

FILE: tb/sv/hsv_to_rgb_converter_tb.sv
// Self-checking testbench for hsv_to_rgb_converter: directed, streaming and drain tests.
// Depends on h2r_pkg and the converter RTL; expected pixels come from a built-in predictor.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import h2r_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [HUE_W-1:0] in_hue_degrees;
  logic [CH_W-1:0] in_saturation;
  logic [CH_W-1:0] in_brightness;
  logic out_valid;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;

  rgb_t pending_rgb_q[$];
  int mismatch_count = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int grey_pixels = 0;
  int wrapped_pixels = 0;
  int sector_hits[6] = '{default: 0};

  hsv_to_rgb_converter i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_hue_degrees(in_hue_degrees),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid(out_valid),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d pixels still pending", pending_rgb_q.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic rgb_t hsv_to_rgb_predict(input logic [HUE_W-1:0] hue_in,
                                               input logic [CH_W-1:0] sat,
                                               input logic [CH_W-1:0] val);
    int unsigned hue;
    int unsigned rem;
    int unsigned s;
    int unsigned v;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t sec;
    rgb_t rgb;
    hue = hue_in % HUE_SPAN;
    rem = hue % SECTOR_DEG;
    sec = sector_t'(hue / SECTOR_DEG);
    s = sat;
    v = val;
    p = (v * (FULL_SCALE - s)) / FULL_SCALE;
    q = (v * (DEN_Q - s * rem)) / DEN_Q;
    t = (v * (DEN_Q - s * (SECTOR_DEG - rem))) / DEN_Q;
    if (s == 0) begin
      rgb = '{val, val, val};
    end else begin
      case (sec)
        SEC_RED_YEL: rgb = '{v[7:0], t[7:0], p[7:0]};
        SEC_YEL_GRN: rgb = '{q[7:0], v[7:0], p[7:0]};
        SEC_GRN_CYN: rgb = '{p[7:0], v[7:0], t[7:0]};
        SEC_CYN_BLU: rgb = '{p[7:0], q[7:0], v[7:0]};
        SEC_BLU_MAG: rgb = '{t[7:0], p[7:0], v[7:0]};
        default:     rgb = '{v[7:0], p[7:0], q[7:0]};
      endcase
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic send_pixel(input logic [HUE_W-1:0] hue,
                            input logic [CH_W-1:0] sat,
                            input logic [CH_W-1:0] val);
    @(negedge clk);
    start <= 1'b1;
    in_hue_degrees <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_rgb_q = {pending_rgb_q, hsv_to_rgb_predict(hue, sat, val)};
    pixels_sent++;
    sector_hits[(hue % HUE_SPAN) / SECTOR_DEG]++;
    if (sat == 0) grey_pixels++;
    if (hue >= HUE_SPAN) wrapped_pixels++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [HUE_W-1:0] random_hue();
    int r;
    int edge_hue;
    r = $urandom_range(99);
    if (r < 82) return HUE_W'($urandom_range(HUE_SPAN - 1, 0));
    if (r < 90) begin
      edge_hue = SECTOR_DEG * $urandom_range(6, 0) + $urandom_range(1, 0) - 1;
      if (edge_hue < 0) edge_hue = 0;
      return HUE_W'(edge_hue);
    end
    return HUE_W'($urandom_range((1 << HUE_W) - 1, HUE_SPAN));
  endfunction

  function automatic logic [CH_W-1:0] random_channel();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return CH_W'($urandom_range((1 << CH_W) - 1, 0));
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_rgb_q.size() == 0) begin
        report_mismatch("unexpected result, red", int'(out_red), 0);
      end else begin
        want = pending_rgb_q.pop_front();
        pixels_checked++;
        if (out_red !== want.red) begin
          report_mismatch("red", int'(out_red), int'(want.red));
        end
        if (out_green !== want.green) begin
          report_mismatch("green", int'(out_green), int'(want.green));
        end
        if (out_blue !== want.blue) begin
          report_mismatch("blue", int'(out_blue), int'(want.blue));
        end
      end
    end
  end

  task automatic test_directed();
    send_pixel(9'd0, 8'd255, 8'd255);
    send_pixel(9'd59, 8'd255, 8'd255);
    send_pixel(9'd60, 8'd255, 8'd255);
    send_pixel(9'd119, 8'd200, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd128);
    send_pixel(9'd179, 8'd1, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd1);
    send_pixel(9'd240, 8'd128, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd30, 8'd0, 8'd0);
    send_pixel(9'd200, 8'd0, 8'd255);
    send_pixel(9'd90, 8'd0, 8'd77);
    send_pixel(9'd45, 8'd255, 8'd0);
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd419, 8'd255, 8'd255);
    send_pixel(9'd420, 8'd170, 8'd200);
    send_pixel(9'd479, 8'd255, 8'd255);
    send_pixel(9'd480, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd256, 8'd85, 8'd170);
    send_pixel(9'd150, 8'd255, 8'd255);
    idle_cycles(1);
  endtask

  task automatic test_random_stream(input int bursts, input int per_burst);
    for (int b = 0; b < bursts; b++) begin
      for (int i = 0; i < per_burst; i++) begin
        send_pixel(random_hue(), random_channel(), random_channel());
        if (b % 2 == 1) idle_cycles(pick_gap());
      end
    end
    idle_cycles(1);
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 10; i++) begin
        send_pixel(random_hue(), random_channel(), random_channel());
      end
      idle_cycles(1);
      while (pending_rgb_q.size() != 0) @(posedge clk);
      idle_cycles($urandom_range(5, 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_hue_degrees = '0;
    in_saturation = '0;
    in_brightness = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_drain_pause();
    test_random_stream(16, 100);

    while (pending_rgb_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Converted %0d pixels (%0d checked): %0d grey, %0d with hue past 359.",
             pixels_sent, pixels_checked, grey_pixels, wrapped_pixels);
    $display("Sector hits: %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
             sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: hsv_to_rgb_converter.f
+incdir+rtl
rtl/h2r_pkg.sv
rtl/h2r_sector.sv
rtl/h2r_scale.sv
rtl/h2r_divide.sv
rtl/hsv_to_rgb_converter.sv
tb/sv/hsv_to_rgb_converter_tb.sv
